// ----- rtl/jet_colormap_pixel_macros.svh -----
// Assertion macros for the jet colormap pixel block.
`ifndef JET_COLORMAP_PIXEL_MACROS_SVH
`define JET_COLORMAP_PIXEL_MACROS_SVH

`ifndef SYNTH
`define JCM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jet colormap: same-cycle check failed");
`define JCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jet colormap: next-cycle check failed");
`else
`define JCM_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define JCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/jcm_pkg.sv -----
// Shared constants, types and the jet color function.
`timescale 1ns / 1ps

package jcm_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int DIFF_W       = SAMPLE_WIDTH + 1;
    localparam int MAG_W        = SAMPLE_WIDTH;
    localparam int LEVEL_W      = 8;
    localparam int COLOR_W      = 8;
    localparam int PROD_W       = SAMPLE_WIDTH + LEVEL_W;
    localparam int DIV_STAGES   = 4;
    localparam int DIV_STEPS    = LEVEL_W / DIV_STAGES;
    localparam int FIRST_DIV    = 3;
    localparam int LAST_DIV     = FIRST_DIV + DIV_STAGES - 1;
    localparam int LEVEL_STAGE  = LAST_DIV + 1;
    localparam int OUT_STAGE    = LEVEL_STAGE + 1;
    localparam int NUM_STAGES   = OUT_STAGE + 1;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [ADDR_W-1:0] REG_RANGE_MIN = 3'd0;
    localparam logic [ADDR_W-1:0] REG_RANGE_MAX = 3'd4;

    localparam logic [SAMPLE_WIDTH-1:0] RANGE_MIN_RESET = '0;
    localparam logic [SAMPLE_WIDTH-1:0] RANGE_MAX_RESET = SAMPLE_WIDTH'(32767);

    localparam logic [LEVEL_W-1:0] LEVEL_BOTTOM = '0;
    localparam logic [LEVEL_W-1:0] LEVEL_TOP    = '1;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } rgb_t;

    function automatic rgb_t jet_color(input logic [LEVEL_W-1:0] level);
        logic [10:0] four;
        rgb_t        c;
        four = {1'b0, level, 2'b00};
        c    = '0;
        case (level) inside
            LEVEL_BOTTOM:
            begin
                c.red   = 8'd1;
                c.green = 8'd1;
                c.blue  = 8'd1;
            end
            LEVEL_TOP:
            begin
                c.red   = 8'd255;
                c.green = 8'd255;
                c.blue  = 8'd255;
            end
            [8'd1:8'd32]:
            begin
                c.blue = 8'(11'd127 + four);
            end
            [8'd33:8'd95]:
            begin
                c.green = 8'(four - 11'd128);
                c.blue  = 8'd255;
            end
            [8'd96:8'd159]:
            begin
                c.red   = 8'(four - 11'd384);
                c.green = 8'd255;
                c.blue  = 8'(11'd639 - four);
            end
            [8'd160:8'd223]:
            begin
                c.red   = 8'd255;
                c.green = 8'(11'd895 - four);
            end
            default:
            begin
                c.red = 8'(11'd1151 - four);
            end
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/jcm_sample_if.sv -----
// Stream channel interfaces for samples in and colored pixels out.
`timescale 1ns / 1ps

interface jcm_sample_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [jcm_pkg::SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface jcm_pixel_if;
    logic                         valid;
    logic                         ready;
    logic [jcm_pkg::COLOR_W-1:0]  red;
    logic [jcm_pkg::COLOR_W-1:0]  green;
    logic [jcm_pkg::COLOR_W-1:0]  blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- rtl/jet_colormap_pixel.sv -----
// Jet colormap: scales one signed sample to a level and colors it.
// Throughput: one sample per cycle; the 9-stage pipeline freezes as a whole
// while a finished pixel waits, and the 8-bit divider is spread over 4 stages.
// Reset: rst_n clears all valid bits and loads range_min = 0, range_max = 32767.
`timescale 1ns / 1ps
`include "jet_colormap_pixel_macros.svh"

module jet_colormap_pixel (
    input  logic                           clk,
    input  logic                           rst_n,
    jcm_sample_if.sink                     sample_ch,
    jcm_pixel_if.source                    pixel_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [jcm_pkg::ADDR_W-1:0]     paddr,
    input  logic [jcm_pkg::DATA_W-1:0]     pwdata,
    output logic [jcm_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    logic signed [jcm_pkg::SAMPLE_WIDTH-1:0] range_min_reg;
    logic signed [jcm_pkg::SAMPLE_WIDTH-1:0] range_max_reg;
    logic                                    cfg_write;

    logic                                    advance;
    logic [jcm_pkg::NUM_STAGES-1:0]          pipe_valid_reg;

    logic signed [jcm_pkg::DIFF_W-1:0]       num_reg;
    logic signed [jcm_pkg::DIFF_W-1:0]       den_reg;

    logic [jcm_pkg::MAG_W-1:0]               num_mag_reg;
    logic [jcm_pkg::MAG_W-1:0]               den_mag_reg;
    logic                                    zero_reg;

    logic [jcm_pkg::PROD_W-1:0]              prod_reg;
    logic [jcm_pkg::MAG_W-1:0]               prod_den_reg;
    logic                                    prod_zero_reg;

    logic [jcm_pkg::PROD_W-1:0]              div_rem_reg  [jcm_pkg::DIV_STAGES];
    logic [jcm_pkg::LEVEL_W-1:0]             div_quo_reg  [jcm_pkg::DIV_STAGES];
    logic [jcm_pkg::MAG_W-1:0]               div_den_reg  [jcm_pkg::DIV_STAGES];
    logic                                    div_zero_reg [jcm_pkg::DIV_STAGES];
    logic                                    div_sat_reg  [jcm_pkg::DIV_STAGES];

    logic [jcm_pkg::PROD_W-1:0]              div_rem_next [jcm_pkg::DIV_STAGES];
    logic [jcm_pkg::LEVEL_W-1:0]             div_quo_next [jcm_pkg::DIV_STAGES];
    logic                                    div_sat_next;

    logic [jcm_pkg::LEVEL_W-1:0]             level_reg;
    logic [jcm_pkg::LEVEL_W-1:0]             level_next;
    jcm_pkg::rgb_t                           rgb_reg;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg <= jcm_pkg::RANGE_MIN_RESET;
            range_max_reg <= jcm_pkg::RANGE_MAX_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr)
                jcm_pkg::REG_RANGE_MIN: range_min_reg <= pwdata[jcm_pkg::SAMPLE_WIDTH-1:0];
                jcm_pkg::REG_RANGE_MAX: range_max_reg <= pwdata[jcm_pkg::SAMPLE_WIDTH-1:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            jcm_pkg::REG_RANGE_MIN: prdata = jcm_pkg::DATA_W'(range_min_reg);
            jcm_pkg::REG_RANGE_MAX: prdata = jcm_pkg::DATA_W'(range_max_reg);
            default:                prdata = '0;
        endcase
    end

    // pipeline control: advance whenever the output slot is free or taken
    assign advance         = !pipe_valid_reg[jcm_pkg::OUT_STAGE] || pixel_ch.ready;
    assign sample_ch.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= '0;
        end
        else if (advance)
        begin
            pipe_valid_reg <= {pipe_valid_reg[jcm_pkg::NUM_STAGES-2:0], sample_ch.valid};
        end
    end

    // restoring divider, two quotient bits per stage; saturation checked up front
    always_comb
    begin
        logic [jcm_pkg::PROD_W-1:0]  rem_v;
        logic [jcm_pkg::LEVEL_W-1:0] quo_v;
        logic [jcm_pkg::MAG_W-1:0]   den_v;
        logic [jcm_pkg::PROD_W-1:0]  shifted_v;
        int                          k;
        div_sat_next = prod_reg >= (jcm_pkg::PROD_W'(prod_den_reg) << jcm_pkg::LEVEL_W);
        for (int j = 0; j < jcm_pkg::DIV_STAGES; j++)
        begin
            if (j == 0)
            begin
                rem_v = prod_reg;
                quo_v = '0;
                den_v = prod_den_reg;
            end
            else
            begin
                rem_v = div_rem_reg[j-1];
                quo_v = div_quo_reg[j-1];
                den_v = div_den_reg[j-1];
            end
            for (int s = 0; s < jcm_pkg::DIV_STEPS; s++)
            begin
                k         = jcm_pkg::LEVEL_W - 1 - j * jcm_pkg::DIV_STEPS - s;
                shifted_v = jcm_pkg::PROD_W'(den_v) << k;
                if (rem_v >= shifted_v)
                begin
                    rem_v    = rem_v - shifted_v;
                    quo_v[k] = 1'b1;
                end
            end
            div_rem_next[j] = rem_v;
            div_quo_next[j] = quo_v;
        end
    end

    always_comb
    begin
        if (div_zero_reg[jcm_pkg::DIV_STAGES-1])
        begin
            level_next = jcm_pkg::LEVEL_BOTTOM;
        end
        else if (div_sat_reg[jcm_pkg::DIV_STAGES-1])
        begin
            level_next = jcm_pkg::LEVEL_TOP;
        end
        else
        begin
            level_next = div_quo_reg[jcm_pkg::DIV_STAGES-1];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            num_reg <= jcm_pkg::DIFF_W'(sample_ch.sample) - jcm_pkg::DIFF_W'(range_min_reg);
            den_reg <= jcm_pkg::DIFF_W'(range_max_reg) - jcm_pkg::DIFF_W'(range_min_reg);

            num_mag_reg <= num_reg[jcm_pkg::DIFF_W-1] ? jcm_pkg::MAG_W'(-num_reg)
                                                       : jcm_pkg::MAG_W'(num_reg);
            den_mag_reg <= den_reg[jcm_pkg::DIFF_W-1] ? jcm_pkg::MAG_W'(-den_reg)
                                                       : jcm_pkg::MAG_W'(den_reg);
            zero_reg    <= (den_reg == '0)
                           || (num_reg[jcm_pkg::DIFF_W-1] != den_reg[jcm_pkg::DIFF_W-1]);

            prod_reg      <= (jcm_pkg::PROD_W'(num_mag_reg) << jcm_pkg::LEVEL_W)
                             - jcm_pkg::PROD_W'(num_mag_reg);
            prod_den_reg  <= den_mag_reg;
            prod_zero_reg <= zero_reg;

            for (int j = 0; j < jcm_pkg::DIV_STAGES; j++)
            begin
                div_rem_reg[j] <= div_rem_next[j];
                div_quo_reg[j] <= div_quo_next[j];
                if (j == 0)
                begin
                    div_den_reg[j]  <= prod_den_reg;
                    div_zero_reg[j] <= prod_zero_reg;
                    div_sat_reg[j]  <= div_sat_next;
                end
                else
                begin
                    div_den_reg[j]  <= div_den_reg[j-1];
                    div_zero_reg[j] <= div_zero_reg[j-1];
                    div_sat_reg[j]  <= div_sat_reg[j-1];
                end
            end

            level_reg <= level_next;
            rgb_reg   <= jcm_pkg::jet_color(level_reg);
        end
    end

    assign pixel_ch.valid = pipe_valid_reg[jcm_pkg::OUT_STAGE];
    assign pixel_ch.red   = rgb_reg.red;
    assign pixel_ch.green = rgb_reg.green;
    assign pixel_ch.blue  = rgb_reg.blue;

    `JCM_ASSERT_SAME(a_rem_below_den, clk, rst_n, pipe_valid_reg[jcm_pkg::LAST_DIV] && !div_sat_reg[jcm_pkg::DIV_STAGES-1] && !div_zero_reg[jcm_pkg::DIV_STAGES-1], div_rem_reg[jcm_pkg::DIV_STAGES-1] < jcm_pkg::PROD_W'(div_den_reg[jcm_pkg::DIV_STAGES-1]))
    `JCM_ASSERT_NEXT(a_sat_to_top, clk, rst_n, pipe_valid_reg[jcm_pkg::LAST_DIV] && advance && div_sat_reg[jcm_pkg::DIV_STAGES-1] && !div_zero_reg[jcm_pkg::DIV_STAGES-1], level_reg == jcm_pkg::LEVEL_TOP)
    `JCM_ASSERT_NEXT(a_bottom_near_black, clk, rst_n, pipe_valid_reg[jcm_pkg::LEVEL_STAGE] && advance && level_reg == jcm_pkg::LEVEL_BOTTOM, pixel_ch.red == 8'd1 && pixel_ch.green == 8'd1 && pixel_ch.blue == 8'd1)
    `JCM_ASSERT_NEXT(a_stall_freezes, clk, rst_n, !advance, $stable(pipe_valid_reg))

endmodule
